// File: sv/prtt_pkg.sv
package prtt_pkg;

  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned LIMIT_W   = 18;   // 255 * 1000 fits
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned MS_PER_SEC = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMITED = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_CHECK = 2'd2,
    OP_SWEEP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LATE    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_APPEND = 2'd1,
    CM_ROTATE = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       keep;
  } cell_ctl_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
    logic                 expired;
    logic                 finished;
  } result_t;

endpackage

// File: sv/pending_request_timeout_tracker.sv
// Pending request tracker with reply timeout.
// Input channel (in_valid_i / in_stall_o) carries one beat per operation: opcode_i,
// seq_i, no_sends_left_i. Output channel (out_valid_o / out_stall_i) returns one beat
// per operation: status_o, pending_count_o, any_expired_o, finished_o.
// Entries live in a chain of cells, oldest at cell 0. Tick and add finish in the
// accept cycle; the result passes through a holding register into the output register,
// and these ops can be taken every cycle while the output does not stall. Check and
// sweep rotate the live entries once through the chain, one entry per cycle past the
// compare unit at cell 0, and write the result on the last step (at accept when empty).
// Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i, index 0 timeout in seconds,
// index 1 count-limited flag; write only while idle.
// Reset empties the table, zeroes time and the expired flag, sets the timeout to 1 s.
// A stalled result holds in the output register; one more result may finish into a
// holding register behind it, after which the input stalls.
module pending_request_timeout_tracker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prtt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [prtt_pkg::CFG_DAT_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic [prtt_pkg::SEQ_W-1:0]          seq_i,
  input  logic                                no_sends_left_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [prtt_pkg::CNT_OUT_W-1:0]      pending_count_o,
  output logic                                any_expired_o,
  output logic                                finished_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  prtt_pkg::state_e  state_q, state_d;
  prtt_pkg::op_e     op_q, op_d, in_op;
  prtt_pkg::status_e st_q, st_d;
  prtt_pkg::result_t res_q, res_new, out_q;
  prtt_pkg::cell_ctl_t ctl;
  prtt_pkg::entry_t  ins;
  prtt_pkg::entry_t  ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] used_vec;

  logic [IW-1:0]                    ptr;
  logic [CW-1:0]                    cnt_q, cnt_d, cnt_m1, steps_q, steps_d;
  logic [prtt_pkg::STAMP_W-1:0]     time_q, time_d, age, limit32;
  logic [prtt_pkg::LIMIT_W-1:0]     limit_q;
  logic [prtt_pkg::SEQ_W-1:0]       seq_q, seq_d;
  logic                             cnt_lim_q, exp_q, exp_d, found_q, found_d, nsl_q, nsl_d;
  logic                             res_valid_q, out_valid_q, res_wr, res_move, in_acc;
  logic                             hit, late, expire, drop;

  function automatic logic [prtt_pkg::CNT_OUT_W-1:0] sat_cnt(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'd127) ? prtt_pkg::CNT_OUT_W'(127) : w[prtt_pkg::CNT_OUT_W-1:0];
  endfunction

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    prtt_pkg::entry_t nbr;
    logic             nbr_used;
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign nbr      = ent[i+1];
      assign nbr_used = used_vec[i+1];
    end else begin : g_last
      assign nbr      = '0;
      assign nbr_used = 1'b0;
    end
    prtt_cell #(
      .DEPTH(TABLE_DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .ptr_i     (ptr),
      .ins_i     (ins),
      .nbr_i     (nbr),
      .nbr_used_i(nbr_used),
      .ent_o     (ent[i]),
      .used_o    (used_vec[i])
    );
  end

  // ---------------- head compare ----------------
  assign in_op   = prtt_pkg::op_e'(opcode_i);
  assign cnt_m1  = cnt_q - 1'b1;
  assign limit32 = 32'(limit_q);
  assign age     = time_q - ent[0].stamp;
  assign hit     = !found_q && (ent[0].seq == seq_q);
  assign late    = age > limit32;
  assign expire  = age >= limit32;
  assign drop    = (op_q == prtt_pkg::OP_CHECK) ? (hit && late) : expire;

  assign res_move   = res_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != prtt_pkg::S_IDLE) || (res_valid_q && !res_move);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prtt_pkg::S_IDLE: begin
        if (in_acc && (in_op == prtt_pkg::OP_CHECK || in_op == prtt_pkg::OP_SWEEP) &&
            (cnt_q != '0)) begin
          state_d = prtt_pkg::S_SCAN;
        end
      end
      prtt_pkg::S_SCAN: begin
        if (steps_q == CW'(1)) begin
          state_d = prtt_pkg::S_IDLE;
        end
      end
      default: state_d = prtt_pkg::S_IDLE;
    endcase
  end

  // ---------------- datapath / outputs ----------------
  always_comb begin
    ctl     = '{mode: prtt_pkg::CM_HOLD, keep: 1'b0};
    ptr     = '0;
    ins     = ent[0];
    time_d  = time_q;
    cnt_d   = cnt_q;
    steps_d = steps_q;
    found_d = found_q;
    st_d    = st_q;
    exp_d   = exp_q;
    op_d    = op_q;
    seq_d   = seq_q;
    nsl_d   = nsl_q;
    res_wr  = 1'b0;
    res_new = res_q;
    unique case (state_q)
      prtt_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d    = in_op;
          seq_d   = seq_i;
          nsl_d   = no_sends_left_i;
          found_d = 1'b0;
          steps_d = cnt_q;
          st_d    = (in_op == prtt_pkg::OP_CHECK) ? prtt_pkg::ST_UNKNOWN : prtt_pkg::ST_OK;
          res_new = '{status: prtt_pkg::ST_OK, count: sat_cnt(cnt_q), expired: exp_q,
                      finished: 1'b0};
          case (in_op) inside
            prtt_pkg::OP_TICK: begin
              time_d = time_q + 1'b1;
              res_wr = 1'b1;
            end
            prtt_pkg::OP_ADD: begin
              res_wr = 1'b1;
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                res_new.status = prtt_pkg::ST_FULL;
              end else begin
                ctl.mode      = prtt_pkg::CM_APPEND;
                ptr           = cnt_q[IW-1:0];
                ins           = '{seq: seq_i, stamp: time_q};
                cnt_d         = cnt_q + 1'b1;
                res_new.count = sat_cnt(cnt_d);
              end
            end
            prtt_pkg::OP_CHECK, prtt_pkg::OP_SWEEP: begin
              // empty table: answer at once
              if (cnt_q == '0) begin
                res_wr           = 1'b1;
                res_new.status   = st_d;
                res_new.finished = (in_op == prtt_pkg::OP_SWEEP) && cnt_lim_q &&
                                   no_sends_left_i;
              end
            end
            default: ;
          endcase
        end
      end
      prtt_pkg::S_SCAN: begin
        ctl.mode = prtt_pkg::CM_ROTATE;
        ctl.keep = !drop;
        ptr      = cnt_m1[IW-1:0];
        ins      = ent[0];
        steps_d  = steps_q - 1'b1;
        if (drop) begin
          cnt_d = cnt_m1;
        end
        if (op_q == prtt_pkg::OP_CHECK) begin
          found_d = found_q || hit;
          if (hit) begin
            st_d = late ? prtt_pkg::ST_LATE : prtt_pkg::ST_OK;
          end
        end else begin
          exp_d = exp_q || drop;
        end
        if (steps_q == CW'(1)) begin
          res_wr  = 1'b1;
          res_new = '{status: st_d, count: sat_cnt(cnt_d), expired: exp_d,
                      finished: (op_q == prtt_pkg::OP_SWEEP) && (cnt_d == '0) &&
                                cnt_lim_q && nsl_q};
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prtt_pkg::S_IDLE;
      cnt_q       <= '0;
      steps_q     <= '0;
      time_q      <= '0;
      exp_q       <= 1'b0;
      limit_q     <= prtt_pkg::LIMIT_W'(prtt_pkg::MS_PER_SEC);
      cnt_lim_q   <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      time_q      <= time_d;
      exp_q       <= exp_d;
      res_valid_q <= (res_valid_q && !res_move) || res_wr;
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          prtt_pkg::REG_TIMEOUT: begin
            limit_q <= prtt_pkg::LIMIT_W'(cfg_wdata_i) *
                       prtt_pkg::LIMIT_W'(prtt_pkg::MS_PER_SEC);
          end
          prtt_pkg::REG_COUNT_LIMITED: cnt_lim_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    seq_q   <= seq_d;
    nsl_q   <= nsl_d;
    found_q <= found_d;
    st_q    <= st_d;
    if (res_wr) begin
      res_q <= res_new;
    end
    if (res_move) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign pending_count_o = out_q.count;
  assign any_expired_o   = out_q.expired;
  assign finished_o      = out_q.finished;

  // ---------------- assertions ----------------
  a_used_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_vec) == int'(cnt_q))
    else $error("used bits disagree with entry count");

  a_scan_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prtt_pkg::S_SCAN) |-> (steps_q != '0) && (steps_q <= cnt_q))
    else $error("scan step count out of range");

  a_held_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_move) |=> (res_valid_q && $stable(res_q)))
    else $error("waiting result lost or overwritten");

endmodule

// File: sv/prtt_cell.sv
module prtt_cell #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX   = 0,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prtt_pkg::cell_ctl_t ctl_i,
  input  logic [IW-1:0]       ptr_i,
  input  prtt_pkg::entry_t    ins_i,
  input  prtt_pkg::entry_t    nbr_i,
  input  logic                nbr_used_i,
  output prtt_pkg::entry_t    ent_o,
  output logic                used_o
);

  prtt_pkg::entry_t ent_q, ent_d;
  logic             used_q, used_d;

  always_comb begin
    ent_d  = ent_q;
    used_d = used_q;
    case (ctl_i.mode)
      prtt_pkg::CM_APPEND: begin
        if (ptr_i == IW'(IDX)) begin
          ent_d  = ins_i;
          used_d = 1'b1;
        end
      end
      prtt_pkg::CM_ROTATE: begin
        // cells ahead of the tail pull from the neighbor, the tail takes the head entry back
        if (IW'(IDX) < ptr_i) begin
          ent_d  = nbr_i;
          used_d = nbr_used_i;
        end else if (IW'(IDX) == ptr_i) begin
          ent_d  = ins_i;
          used_d = ctl_i.keep;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o  = ent_q;
  assign used_o = used_q;

endmodule
